// File: rtl/modbus_rtu_slave_register_engine_unit_assert.svh
// assertion macros for the modbus rtu slave register engine
`ifndef MODBUS_RTU_SLAVE_REGISTER_ENGINE_UNIT_ASSERT_SVH
`define MODBUS_RTU_SLAVE_REGISTER_ENGINE_UNIT_ASSERT_SVH

// combinational invariant, checked at every clock edge outside reset
`define MRTU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// next-cycle implication
`define MRTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mrtu_pkg.sv
// shared types, constants and the crc step for the modbus rtu slave
`default_nettype none
package mrtu_pkg;

  localparam int RX_DEPTH_DEF  = 256;
  localparam int REG_COUNT_DEF = 64;
  localparam int TX_DEPTH      = 256;
  localparam int TXW           = 8;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_SILENCE    = 2'd1;
  localparam logic [1:0] CFG_ADU_MODE   = 2'd2;

  localparam logic [7:0] FC_READ_HOLD   = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

  localparam logic [7:0] EXC_NONE          = 8'h00;
  localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;
  localparam logic [7:0] EXC_FLAG          = 8'h80;

  localparam logic [15:0] QTY_MAX  = 16'h007D;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    PH_INIT, PH_IDLE, PH_RECV, PH_EMIT, PH_ERROR
  } phase_t;

  typedef enum logic [4:0] {
    S_WAIT, S_RESULT, S_E_RD, S_E_OUT, S_FR_START, S_FETCH, S_FETCH_W,
    S_A_BYTE, S_P_FC, S_P_HDR, S_DECIDE, S_EMITQ, S_RG_RD, S_RG_W,
    S_W_HI, S_W_LO, S_TAIL, S_FR_END
  } seq_t;

  // crc-16/modbus over one byte, reflected polynomial
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mrtu_if.sv
// channel interfaces: tick input, response output, configuration write
`default_nettype none
interface mrtu_tick_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  modport source(output valid, byte_valid, byte_value, input ready);
  modport sink(input valid, byte_valid, byte_value, output ready);
endinterface

interface mrtu_resp_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       overflow_error;
  modport source(output valid, tx_valid, tx_byte, tx_last, overflow_error, input ready);
  modport sink(input valid, tx_valid, tx_byte, tx_last, overflow_error, output ready);
endinterface

interface mrtu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/mrtu_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module mrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/modbus_rtu_slave_register_engine_unit.sv
// modbus rtu slave (fc 03/06/16) driven by timer ticks, sequenced over shared memories
// one tick per transaction: a reply byte is read from the reply buffer before its result
// a frame-ending tick walks the frame: each received byte is fetched for the crc scan,
// then each header or write-data byte, each read register and each reply byte in turn,
// paced by the single rx ram read port and the one-byte-per-cycle crc unit
// sync reset clears control state and marks the register file as all zeros (valid bits)
`default_nettype none
`include "modbus_rtu_slave_register_engine_unit_assert.svh"
module modbus_rtu_slave_register_engine_unit #(
  parameter int RX_DEPTH  = mrtu_pkg::RX_DEPTH_DEF,
  parameter int REG_COUNT = mrtu_pkg::REG_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  mrtu_tick_if.sink      tick,
  mrtu_resp_if.source    resp,
  mrtu_cfg_if.sink       cfg
);
  import mrtu_pkg::*;

  localparam int RXW = $clog2(RX_DEPTH);
  localparam int CW  = RXW + 1;
  localparam int RFW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [CW-1:0] RX_FULL = CW'(RX_DEPTH);
  localparam logic [16:0]   RF_END  = 17'(REG_COUNT);
  localparam logic [8:0]    TX_FULL = 9'(TX_DEPTH);

  // configuration registers
  logic [7:0]  slave_address;
  logic [15:0] silence_ticks;
  logic        adu_mode;

  // sequencer and protocol state
  seq_t        state, state_next, ret, ret_next;
  phase_t      phase;
  logic [15:0] silence_count;
  logic [CW-1:0] rx_count;
  logic [8:0]  tx_length;
  logic [8:0]  tx_position;
  logic        error_latch;

  // frame walk datapath
  logic [CW-1:0] pos;
  logic [7:0]  rd_byte;
  logic [15:0] crc;
  logic [7:0]  crc_lo;
  logic [7:0]  fc;
  logic [39:0] hdr;
  logic [2:0]  hcnt;
  logic [39:0] pend;
  logic [2:0]  pend_n;
  logic [6:0]  idx;
  logic [7:0]  wr_hi;
  logic        rf_vq;
  logic        rf_vld [REG_COUNT];

  // result waiting for the output register
  logic        res_txv;
  logic [7:0]  res_byte;
  logic        res_last;
  logic        out_valid;
  logic        out_txv;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_err;

  // memory ports
  logic            rx_we;
  logic [RXW-1:0]  rx_raddr;
  logic [7:0]      rx_rdata;
  logic            tx_we;
  logic [7:0]      tx_raddr;
  logic [7:0]      tx_rdata;
  logic            rf_we;
  logic [RFW-1:0]  rf_waddr;
  logic [15:0]     rf_wdata;
  logic [RFW-1:0]  rf_raddr;
  logic [15:0]     rf_rdata;

  // put path into the reply buffer
  logic        put_en;
  logic [7:0]  put_data;
  logic [15:0] crc_src;

  // tick decode
  logic          tick_acc;
  logic          bv;
  logic [CW-1:0] rx_count_inc;
  logic [15:0]   sil_inc;
  logic          sil_reach;
  logic          ovf;

  // header fields and checks
  logic [15:0] start;
  logic [15:0] qty;
  logic [7:0]  bc;
  logic        qty_ok;
  logic        range_ok;
  logic [7:0]  dec_exc;
  logic [RFW-1:0] rf_addr;
  logic [CW:0] pos_p1;
  logic [CW:0] pos_p2;
  logic [CW:0] lim_w;
  logic [15:0] idx_p1;

  assign cfg.ready = 1'b1;
  assign tick.ready = (state == S_WAIT);
  assign tick_acc  = tick.valid && tick.ready;
  assign bv        = tick.byte_valid;

  assign resp.valid          = out_valid;
  assign resp.tx_valid       = out_txv;
  assign resp.tx_byte        = out_byte;
  assign resp.tx_last        = out_last;
  assign resp.overflow_error = out_err;

  assign rx_count_inc = rx_count + CW'(bv);
  assign sil_inc      = (silence_count == 16'hFFFF) ? silence_count : silence_count + 16'd1;
  assign sil_reach    = !bv && (sil_inc >= silence_ticks);
  assign ovf          = bv && (rx_count_inc == RX_FULL);

  assign start  = hdr[39:24];
  assign qty    = hdr[23:8];
  assign bc     = hdr[7:0];
  assign qty_ok = (qty != 16'd0) && (qty <= QTY_MAX);
  assign range_ok = ({1'b0, start} < RF_END) &&
                    ({1'b0, start} + {1'b0, qty} - 17'd1 < RF_END);
  assign rf_addr = start[RFW-1:0] + RFW'(idx);
  assign pos_p1  = {1'b0, pos} + (CW+1)'(1);
  assign pos_p2  = {1'b0, pos} + (CW+1)'(2);
  assign lim_w   = {1'b0, rx_count};
  assign idx_p1  = 16'(idx) + 16'd1;

  // exception code chosen for the decoded request, quantity test first
  always_comb begin
    dec_exc = EXC_NONE;
    case (fc)
      FC_READ_HOLD: begin
        if (!qty_ok) dec_exc = EXC_ILLEGAL_VALUE;
        else if (!range_ok) dec_exc = EXC_ILLEGAL_ADDR;
      end
      FC_WRITE_ONE: begin
        if ({1'b0, start} >= RF_END) dec_exc = EXC_ILLEGAL_ADDR;
      end
      FC_WRITE_MULTI: begin
        if (!qty_ok || {qty[6:0], 1'b0} != bc) dec_exc = EXC_ILLEGAL_VALUE;
        else if (!range_ok) dec_exc = EXC_ILLEGAL_ADDR;
      end
      default: dec_exc = EXC_ILLEGAL_FUNC;
    endcase
  end

  // configuration writes take effect at once
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      silence_ticks <= 16'd7;
      adu_mode      <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SLAVE_ADDR: slave_address <= cfg.data[7:0];
        CFG_SILENCE:    silence_ticks <= cfg.data;
        CFG_ADU_MODE:   adu_mode      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WAIT;
      ret   <= S_WAIT;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // next state, memory strobes and put path
  always_comb begin
    state_next = state;
    ret_next   = ret;
    rx_we      = 1'b0;
    rx_raddr   = pos[RXW-1:0];
    tx_raddr   = tx_position[7:0];
    rf_we      = 1'b0;
    rf_waddr   = rf_addr;
    rf_wdata   = {wr_hi, rd_byte};
    rf_raddr   = rf_addr;
    put_en     = 1'b0;
    put_data   = pend[39:32];
    crc_src    = crc;
    case (state)
      S_WAIT: begin
        if (tick_acc) begin
          if (phase == PH_EMIT) begin
            state_next = S_E_RD;
          end else if (phase == PH_ERROR) begin
            state_next = S_RESULT;
          end else begin
            rx_we = bv;
            if (!ovf && phase == PH_RECV && sil_reach) state_next = S_FR_START;
            else state_next = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (!out_valid || resp.ready) state_next = S_WAIT;
      end
      S_E_RD:  state_next = S_E_OUT;
      S_E_OUT: state_next = S_RESULT;
      S_FR_START: begin
        if (adu_mode) begin
          if (rx_count < CW'(4)) begin
            state_next = S_FR_END;
          end else begin
            state_next = S_FETCH;
            ret_next   = S_A_BYTE;
          end
        end else begin
          state_next = S_FETCH;
          ret_next   = S_P_FC;
        end
      end
      S_FETCH:   state_next = S_FETCH_W;
      S_FETCH_W: state_next = ret;
      S_A_BYTE: begin
        if (pos == CW'(1) && rd_byte != slave_address) begin
          state_next = S_FR_END;
        end else if (pos_p2 <= lim_w || pos_p1 == lim_w) begin
          state_next = S_FETCH;
        end else if (crc == {rd_byte, crc_lo}) begin
          // frame accepted: echo the station address first
          put_en     = 1'b1;
          put_data   = slave_address;
          crc_src    = CRC_INIT;
          state_next = S_FETCH;
          ret_next   = S_P_FC;
        end else begin
          state_next = S_FR_END;
        end
      end
      S_P_FC: begin
        state_next = S_FETCH;
        ret_next   = S_P_HDR;
      end
      S_P_HDR: begin
        if (hcnt == 3'd4) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_DECIDE: begin
        if (dec_exc != EXC_NONE) begin
          state_next = S_EMITQ;
          ret_next   = S_TAIL;
        end else begin
          case (fc)
            FC_READ_HOLD: begin
              state_next = S_EMITQ;
              ret_next   = S_RG_RD;
            end
            FC_WRITE_ONE: begin
              rf_we      = 1'b1;
              rf_waddr   = start[RFW-1:0];
              rf_wdata   = qty;
              state_next = S_EMITQ;
              ret_next   = S_TAIL;
            end
            default: begin
              state_next = S_FETCH;
              ret_next   = S_W_HI;
            end
          endcase
        end
      end
      S_EMITQ: begin
        put_en = 1'b1;
        if (pend_n == 3'd1) state_next = ret;
      end
      S_RG_RD: state_next = S_RG_W;
      S_RG_W: begin
        state_next = S_EMITQ;
        ret_next   = (idx_p1 < qty) ? S_RG_RD : S_TAIL;
      end
      S_W_HI: begin
        state_next = S_FETCH;
        ret_next   = S_W_LO;
      end
      S_W_LO: begin
        rf_we = 1'b1;
        if (idx_p1 < qty) begin
          state_next = S_FETCH;
          ret_next   = S_W_HI;
        end else begin
          state_next = S_EMITQ;
          ret_next   = S_TAIL;
        end
      end
      S_TAIL: begin
        if (adu_mode) begin
          state_next = S_EMITQ;
          ret_next   = S_FR_END;
        end else begin
          state_next = S_FR_END;
        end
      end
      S_FR_END: state_next = S_RESULT;
      default:  state_next = S_WAIT;
    endcase
  end

  assign tx_we = put_en && (tx_length < TX_FULL);

  // protocol control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_INIT;
      silence_count <= 16'd0;
      rx_count      <= '0;
      tx_length     <= 9'd0;
      tx_position   <= 9'd0;
      error_latch   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && resp.ready) out_valid <= 1'b0;
      if (state == S_RESULT && (!out_valid || resp.ready)) out_valid <= 1'b1;
      if (put_en && tx_length < TX_FULL) tx_length <= tx_length + 9'd1;
      case (state)
        S_WAIT: begin
          if (tick_acc && phase != PH_EMIT && phase != PH_ERROR) begin
            if (bv) rx_count <= rx_count_inc;
            if (ovf) begin
              error_latch <= 1'b1;
              phase       <= PH_ERROR;
            end else begin
              case (phase)
                PH_INIT: begin
                  silence_count <= bv ? 16'd0 : sil_inc;
                  if (sil_reach) begin
                    rx_count <= '0;
                    phase    <= PH_IDLE;
                  end
                end
                PH_IDLE: begin
                  if (bv) begin
                    silence_count <= 16'd0;
                    phase         <= PH_RECV;
                  end
                end
                default: silence_count <= bv ? 16'd0 : sil_inc;
              endcase
            end
          end
        end
        S_E_OUT: begin
          if (tx_position < tx_length) begin
            tx_position <= tx_position + 9'd1;
            if (tx_position + 9'd1 >= tx_length) begin
              phase    <= PH_IDLE;
              rx_count <= '0;
            end
          end else begin
            phase    <= PH_IDLE;
            rx_count <= '0;
          end
        end
        S_FR_START: tx_length <= 9'd0;
        S_FR_END: begin
          rx_count    <= '0;
          tx_position <= 9'd0;
          phase       <= (tx_length != 9'd0) ? PH_EMIT : PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // register file valid bits, cleared at reset so unwritten entries read zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < REG_COUNT; r++) rf_vld[r] <= 1'b0;
    end else if (rf_we) begin
      rf_vld[rf_waddr] <= 1'b1;
    end
  end

  // frame walk payload registers and result assembly
  always_ff @(posedge clk) begin
    if (put_en) crc <= crc_byte(crc_src, put_data);
    case (state)
      S_WAIT: begin
        res_txv  <= 1'b0;
        res_byte <= 8'd0;
        res_last <= 1'b0;
      end
      S_RESULT: begin
        if (!out_valid || resp.ready) begin
          out_txv  <= res_txv;
          out_byte <= res_byte;
          out_last <= res_last;
          out_err  <= error_latch;
        end
      end
      S_E_OUT: begin
        res_txv  <= (tx_position < tx_length);
        res_byte <= (tx_position < tx_length) ? tx_rdata : 8'd0;
        res_last <= (tx_position < tx_length) && (tx_position + 9'd1 >= tx_length);
      end
      S_FR_START: begin
        pos  <= '0;
        crc  <= CRC_INIT;
        hcnt <= 3'd0;
        idx  <= 7'd0;
      end
      S_FETCH_W: begin
        rd_byte <= (pos < rx_count) ? rx_rdata : 8'd0;
        if (pos != RX_FULL) pos <= pos + CW'(1);
      end
      S_A_BYTE: begin
        if (pos_p2 <= lim_w) begin
          crc <= crc_byte(crc, rd_byte);
        end else if (pos_p1 == lim_w) begin
          crc_lo <= rd_byte;
        end else begin
          pos <= CW'(1);
        end
      end
      S_P_FC: fc <= rd_byte;
      S_P_HDR: begin
        hdr  <= {hdr[31:0], rd_byte};
        hcnt <= hcnt + 3'd1;
      end
      S_DECIDE: begin
        if (dec_exc != EXC_NONE) begin
          pend   <= {fc + EXC_FLAG, dec_exc, 24'd0};
          pend_n <= 3'd2;
        end else if (fc == FC_READ_HOLD) begin
          pend   <= {FC_READ_HOLD, qty[6:0], 1'b0, 24'd0};
          pend_n <= 3'd2;
        end else begin
          pend   <= {FC_WRITE_ONE, start, qty};
          pend_n <= 3'd5;
        end
      end
      S_EMITQ: begin
        pend   <= {pend[31:0], 8'd0};
        pend_n <= pend_n - 3'd1;
      end
      S_RG_RD: rf_vq <= rf_vld[rf_raddr];
      S_RG_W: begin
        pend   <= {(rf_vq ? rf_rdata : 16'd0), 24'd0};
        pend_n <= 3'd2;
        idx    <= idx + 7'd1;
      end
      S_W_HI: wr_hi <= rd_byte;
      S_W_LO: begin
        idx    <= idx + 7'd1;
        pend   <= {FC_WRITE_MULTI, start, qty};
        pend_n <= 3'd5;
      end
      S_TAIL: begin
        pend   <= {crc[7:0], crc[15:8], 24'd0};
        pend_n <= 3'd2;
      end
      S_FR_END: begin
        res_txv  <= 1'b0;
        res_byte <= 8'd0;
        res_last <= 1'b0;
      end
      default: ;
    endcase
  end

  // receive buffer, written at the current count on each accepted byte
  mrtu_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_count[RXW-1:0]),
    .wdata (tick.byte_value),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  // reply buffer, filled by the put path and drained one byte per tick
  mrtu_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_length[TXW-1:0]),
    .wdata (put_data),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // holding register file
  mrtu_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_ram (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // the overflow flag never clears outside reset
  `MRTU_ASSERT_NEXT(a_err_sticky, error_latch, error_latch, "overflow latch dropped")
  // while replying, the read position stays inside the reply
  `MRTU_ASSERT_ALWAYS(a_tx_pos, (phase != PH_EMIT) || (tx_position < tx_length), "tx position past reply")
  // receive count only reaches the depth once the block has halted
  `MRTU_ASSERT_ALWAYS(a_rx_cnt, (phase == PH_ERROR) || (rx_count < RX_FULL), "rx count at depth while running")
  // a tick transaction always takes the sequencer out of the wait state
  `MRTU_ASSERT_NEXT(a_busy, tick_acc, !tick.ready, "ready held after tick transaction")

endmodule
`default_nettype wire

// File: verif/tb_modbus_rtu_slave_register_engine_unit.sv
// testbench for the modbus rtu slave register engine: directed frames, random traffic, scoreboard
`default_nettype none
module tb_modbus_rtu_slave_register_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mrtu_pkg::*;

  // one response transaction per tick transaction
  typedef struct packed {
    logic       txv;
    logic [7:0] txb;
    logic       txl;
    logic       ovf;
  } tick_result_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  // directed stimulus row: bytes are right-justified, byte 0 is the most significant one used
  // a reply count of -1 means the reply is left to the predictor alone
  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [15:0] val;
    bit          crc;
    int          n;
    logic [95:0] b;
    int          ne;
    logic [47:0] e;
  } stim_row_t;

  logic clk;
  logic rst;

  mrtu_tick_if tick_ch();
  mrtu_resp_if resp_ch();
  mrtu_cfg_if  cfg_ch();

  modbus_rtu_slave_register_engine_unit dut (
    .clk (clk),
    .rst (rst),
    .tick(tick_ch),
    .resp(resp_ch),
    .cfg (cfg_ch)
  );

  // ------------------------------------------------------------------
  // slave model: configuration copy and state
  // ------------------------------------------------------------------
  logic [7:0]  m_addr;
  logic [15:0] m_sil;
  logic        m_adu;
  phase_t      m_phase;
  int unsigned m_scnt;
  int unsigned m_rxn;
  int unsigned m_txn;
  int unsigned m_txp;
  logic [7:0]  m_rx [256];
  logic [7:0]  m_tx [256];
  logic [15:0] m_regs [64];
  logic        m_err;

  tick_result_t expected_results[$];
  logic [7:0]   reply_log[$];     // predicted reply bytes, used against typed rows

  int  errors;
  int  ticks_sent;
  bit  idle_on;
  bit  hold_req;

  // crc-16/modbus, bitwise, reflected
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ 16'hA001;
      else r = r >> 1;
    end
    return r;
  endfunction

  // payload read; past the end of the frame it yields zero
  function automatic int unsigned fetch8(inout int unsigned pos);
    int unsigned v;
    v = 0;
    if (pos < m_rxn && pos < 256) v = m_rx[pos];
    pos++;
    return v;
  endfunction

  function automatic int unsigned fetch16(inout int unsigned pos);
    int unsigned hi;
    hi = fetch8(pos);
    return (hi << 8) | fetch8(pos);
  endfunction

  function automatic void emit_byte(input int unsigned v);
    if (m_txn < 256) begin
      m_tx[m_txn] = v[7:0];
      m_txn++;
    end
  endfunction

  function automatic void emit16(input int unsigned v);
    emit_byte((v >> 8) & 8'hFF);
    emit_byte(v & 8'hFF);
  endfunction

  function automatic bit qty_legal(input int unsigned q);
    return q >= 1 && q <= QTY_MAX;
  endfunction

  function automatic bit span_legal(input int unsigned start, input int unsigned q);
    return start < 64 && start + q - 1 < 64;
  endfunction

  // decode a finished frame and build the reply in m_tx
  function automatic void decode_frame();
    int unsigned pos, fc, exc, start, qty, val, bc;
    logic [15:0] c;
    logic [15:0] crc_rx;
    pos = 0;
    exc = 0;
    m_txn = 0;
    if (m_adu) begin
      if (m_rxn < 4) return;
      if (m_rx[0] != m_addr) return;
      crc_rx = {m_rx[m_rxn-1], m_rx[m_rxn-2]};
      c = 16'hFFFF;
      for (int i = 0; i < m_rxn - 2; i++) c = crc_step(c, m_rx[i]);
      if (c != crc_rx) return;
      pos = 1;
      emit_byte(m_rx[0]);
    end
    fc = fetch8(pos);
    if (fc == FC_READ_HOLD) begin
      start = fetch16(pos);
      qty = fetch16(pos);
      if (!qty_legal(qty)) exc = EXC_ILLEGAL_VALUE;
      else if (!span_legal(start, qty)) exc = EXC_ILLEGAL_ADDR;
      else begin
        emit_byte(FC_READ_HOLD);
        emit_byte(qty * 2);
        for (int i = 0; i < qty; i++) emit16(m_regs[start + i]);
      end
    end else if (fc == FC_WRITE_ONE) begin
      start = fetch16(pos);
      val = fetch16(pos);
      if (start >= 64) exc = EXC_ILLEGAL_ADDR;
      else begin
        m_regs[start] = val[15:0];
        emit_byte(FC_WRITE_ONE);
        emit16(start);
        emit16(val);
      end
    end else if (fc == FC_WRITE_MULTI) begin
      start = fetch16(pos);
      qty = fetch16(pos);
      bc = fetch8(pos);
      if (!qty_legal(qty) || qty * 2 != bc) exc = EXC_ILLEGAL_VALUE;
      else if (!span_legal(start, qty)) exc = EXC_ILLEGAL_ADDR;
      else begin
        for (int i = 0; i < qty; i++) m_regs[start + i] = fetch16(pos);
        emit_byte(FC_WRITE_MULTI);
        emit16(start);
        emit16(qty);
      end
    end else begin
      exc = EXC_ILLEGAL_FUNC;
    end
    if (exc != 0) begin
      emit_byte((fc + EXC_FLAG) & 8'hFF);
      emit_byte(exc);
    end
    if (m_adu) begin
      c = 16'hFFFF;
      for (int i = 0; i < m_txn; i++) c = crc_step(c, m_tx[i]);
      emit_byte(c[7:0]);
      emit_byte(c[15:8]);
    end
  endfunction

  // byteless ticks count toward silence, a byte restarts the count
  function automatic bit silence_reached(input logic bv);
    if (bv) begin
      m_scnt = 0;
      return 0;
    end
    if (m_scnt < 65535) m_scnt++;
    return m_scnt >= m_sil;
  endfunction

  function automatic tick_result_t predict_tick(input logic bv, input logic [7:0] b);
    tick_result_t r;
    bit halted;
    r = '0;
    halted = 0;
    if (m_phase == PH_EMIT) begin
      if (m_txp < m_txn) begin
        r.txv = 1'b1;
        r.txb = m_tx[m_txp];
        m_txp++;
      end
      if (m_txp >= m_txn) begin
        r.txl = r.txv;
        m_phase = PH_IDLE;
        m_rxn = 0;
      end
    end else if (m_phase != PH_ERROR) begin
      if (bv) begin
        if (m_rxn < 256) m_rx[m_rxn] = b;
        m_rxn++;
        if (m_rxn >= 256) begin
          m_err = 1'b1;
          m_phase = PH_ERROR;
          halted = 1;
        end
      end
      if (!halted) begin
        if (m_phase == PH_INIT) begin
          if (silence_reached(bv)) begin
            m_rxn = 0;
            m_phase = PH_IDLE;
          end
        end else if (m_phase == PH_IDLE) begin
          if (bv) begin
            m_scnt = 0;
            m_phase = PH_RECV;
          end
        end else if (silence_reached(bv)) begin
          decode_frame();
          m_rxn = 0;
          m_txp = 0;
          m_phase = (m_txn != 0) ? PH_EMIT : PH_IDLE;
        end
      end
    end
    r.ovf = m_err;
    if (r.txv) reply_log.push_back(r.txb);
    return r;
  endfunction

  // ------------------------------------------------------------------
  // clock, reset, time limit
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous cap, sized for the long-silence frame
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic note_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned got_v);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
  endtask

  // ------------------------------------------------------------------
  // response side: random stalls, plus one long hold-off on request
  // ------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    resp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the block backs up and stalls its tick input
        hold_req = 0;
        stall = 400;
      end
      if (rst) resp_ch.ready = 1'b0;
      else if (stall > 0) begin
        stall--;
        resp_ch.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        resp_ch.ready = 1'b0;
      end else begin
        resp_ch.ready = 1'b1;
      end
    end
  end

  // scoreboard: every response transaction against the oldest prediction
  always @(posedge clk) begin
    tick_result_t got, want;
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      got = '{resp_ch.tx_valid, resp_ch.tx_byte, resp_ch.tx_last, resp_ch.overflow_error};
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected response", 0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.txv !== want.txv) note_mismatch("tx_valid", want.txv, got.txv);
        if (got.txb !== want.txb) note_mismatch("tx_byte", want.txb, got.txb);
        if (got.txl !== want.txl) note_mismatch("tx_last", want.txl, got.txl);
        if (got.ovf !== want.ovf) note_mismatch("overflow_error", want.ovf, got.ovf);
      end
    end
  end

  // ------------------------------------------------------------------
  // tick and configuration drivers
  // ------------------------------------------------------------------
  task automatic send_tick(input logic bv, input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid = 1'b1;
    tick_ch.byte_valid = bv;
    tick_ch.byte_value = b;
    do @(posedge clk); while (!tick_ch.ready);
    expected_results.push_back(predict_tick(bv, b));
    ticks_sent++;
    @(negedge clk);
    tick_ch.valid = 1'b0;
  endtask

  // registers change only once all responses are in and the block has settled
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_SLAVE_ADDR: m_addr = val[7:0];
      CFG_SILENCE:    m_sil = val;
      CFG_ADU_MODE:   m_adu = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // keep ticking until the block is back to idle; stray bytes during the reply are ignored
  task automatic drain();
    while (m_phase != PH_IDLE && m_phase != PH_ERROR) begin
      if (m_phase == PH_EMIT && $urandom_range(0, 5) == 0) send_tick(1'b1, $urandom_range(0, 255));
      else send_tick(1'b0, $urandom_range(0, 255));
    end
  endtask

  task automatic send_frame(input logic [7:0] fr[$]);
    foreach (fr[i]) send_tick(1'b1, fr[i]);
    drain();
    repeat ($urandom_range(0, 2)) send_tick(1'b0, $urandom_range(0, 255));
  endtask

  function automatic void append_crc(ref logic [7:0] q[$]);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (q[i]) c = crc_step(c, q[i]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
  endfunction

  // mostly well-formed requests, with bad addresses, crcs, counts and truncation mixed in
  function automatic void make_request(ref logic [7:0] q[$]);
    int unsigned kind, sel, start, qty, bc, ndata, bit_pos;
    q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 3)) q.push_back($urandom_range(0, 255));
      return;
    end
    if (m_adu) q.push_back(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : m_addr);
    sel = $urandom_range(0, 9);
    start = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 70);
    if (sel <= 2) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: qty = 0;
            1: qty = QTY_MAX;
            2: qty = QTY_MAX + 1;
            default: qty = $urandom_range(0, 65535);
          endcase
        end
        1: begin
          start = 0;
          qty = $urandom_range(32, 64);
        end
        default: qty = $urandom_range(1, 8);
      endcase
      q.push_back(FC_READ_HOLD);
      q.push_back(start[15:8]);
      q.push_back(start[7:0]);
      q.push_back(qty[15:8]);
      q.push_back(qty[7:0]);
    end else if (sel <= 5) begin
      q.push_back(FC_WRITE_ONE);
      q.push_back(start[15:8]);
      q.push_back(start[7:0]);
      q.push_back($urandom_range(0, 255));
      q.push_back($urandom_range(0, 255));
    end else if (sel <= 7) begin
      qty = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 130) : $urandom_range(1, 6);
      bc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : (qty * 2) & 8'hFF;
      ndata = (qty * 2 > 40) ? 40 : qty * 2;
      q.push_back(FC_WRITE_MULTI);
      q.push_back(start[15:8]);
      q.push_back(start[7:0]);
      q.push_back(qty[15:8]);
      q.push_back(qty[7:0]);
      q.push_back(bc[7:0]);
      repeat (ndata) q.push_back($urandom_range(0, 255));
    end else begin
      q.push_back($urandom_range(0, 255));
      repeat ($urandom_range(0, 4)) q.push_back($urandom_range(0, 255));
    end
    // truncated payload: reads past the end come back as zero
    if ($urandom_range(0, 11) == 0 && q.size() > 2)
      repeat ($urandom_range(1, 2)) void'(q.pop_back());
    if (m_adu) begin
      append_crc(q);
      if ($urandom_range(0, 11) == 0) begin
        bit_pos = $urandom_range(0, 7);
        sel = $urandom_range(0, q.size() - 1);
        q[sel][bit_pos] = ~q[sel][bit_pos];
      end
    end
  endfunction

  // ------------------------------------------------------------------
  // directed stimulus table
  // ------------------------------------------------------------------
  stim_row_t rows[] = '{
    // adu mode, station 1: write, read back, top two registers, dropped frames
    '{ROW_FRAME, 2'd0, 16'd0, 1, 6,  96'h010600001234,         -1, 48'h0},
    '{ROW_FRAME, 2'd0, 16'd0, 1, 6,  96'h010300000001,         -1, 48'h0},
    '{ROW_FRAME, 2'd0, 16'd0, 1, 11, 96'h0110003E000204ABCDFFFF, -1, 48'h0},
    '{ROW_FRAME, 2'd0, 16'd0, 1, 6,  96'h0103003E0002,         -1, 48'h0},
    '{ROW_FRAME, 2'd0, 16'd0, 1, 6,  96'h020300000001,          0, 48'h0},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 8,  96'h0103000000010000,      0, 48'h0},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 2,  96'h0103,                  0, 48'h0},
    '{ROW_CFG,   CFG_ADU_MODE, 16'd0, 0, 0, 96'h0, -1, 48'h0},
    // bare pdu: exceptions and edge addresses
    '{ROW_FRAME, 2'd0, 16'd0, 0, 1,  96'h2B,                    2, 48'hAB01},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 5,  96'h0300000000,            2, 48'h8303},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 5,  96'h030000007E,            2, 48'h8303},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 5,  96'h0300400001,            2, 48'h8302},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 5,  96'h03003F0002,            2, 48'h8302},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 5,  96'h03FFFF007D,            2, 48'h8302},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 5,  96'h0600400001,            2, 48'h8602},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 5,  96'h060005FFFF,            5, 48'h060005FFFF},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 8,  96'h1000000001030000,      2, 48'h9003},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 10, 96'h10003F00020400000000,  2, 48'h9002},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 1,  96'h03,                    2, 48'h8303},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 6,  96'h100001000102,          5, 48'h1000010001},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 5,  96'h03003F0001,            4, 48'h0302FFFF},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 1,  96'h80,                    2, 48'h0001},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 1,  96'hFF,                    2, 48'h7F01},
    '{ROW_FRAME, 2'd0, 16'd0, 0, 1,  96'h00,                    2, 48'h8001},
    '{ROW_CFG,   CFG_SLAVE_ADDR, 16'd247, 0, 0, 96'h0, -1, 48'h0},
    '{ROW_CFG,   CFG_ADU_MODE,   16'd1,   0, 0, 96'h0, -1, 48'h0},
    '{ROW_FRAME, 2'd0, 16'd0, 1, 6,  96'hF70300000001,         -1, 48'h0}
  };

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    logic [7:0] fr[$];
    int rnd_ticks;
    int nframes;
    bit pressed;
    errors = 0;
    ticks_sent = 0;
    idle_on = 1;
    hold_req = 0;
    pressed = 0;
    m_addr = 8'd1;
    m_sil = 16'd7;
    m_adu = 1'b1;
    m_phase = PH_INIT;
    m_scnt = 0;
    m_rxn = 0;
    m_txn = 0;
    m_txp = 0;
    m_err = 1'b0;
    foreach (m_regs[i]) m_regs[i] = '0;
    tick_ch.valid = 1'b0;
    tick_ch.byte_valid = 1'b0;
    tick_ch.byte_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SLAVE_ADDR;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // line noise before the first silence, then wait it out
    repeat (3) send_tick(1'b1, $urandom_range(0, 255));
    drain();

    // directed rows; typed replies are checked against the predicted byte stream
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) begin
        write_reg(rows[r].idx, rows[r].val);
      end else begin
        fr.delete();
        for (int i = 0; i < rows[r].n; i++) fr.push_back(rows[r].b[8*(rows[r].n-1-i) +: 8]);
        if (rows[r].crc) append_crc(fr);
        reply_log.delete();
        send_frame(fr);
        if (rows[r].ne >= 0) begin
          if (reply_log.size() != rows[r].ne) note_mismatch("reply length", rows[r].ne,
                                                            reply_log.size());
          else
            for (int i = 0; i < rows[r].ne; i++)
              if (reply_log[i] !== rows[r].e[8*(rows[r].ne-1-i) +: 8])
                note_mismatch("reply byte", rows[r].e[8*(rows[r].ne-1-i) +: 8], reply_log[i]);
        end
      end
    end

    // random traffic with idling, settings changed between batches
    rnd_ticks = ticks_sent;
    while (ticks_sent - rnd_ticks < 600) begin
      case ($urandom_range(0, 2))
        0: write_reg(CFG_SLAVE_ADDR, 16'd1);
        1: write_reg(CFG_SLAVE_ADDR, 16'd247);
        default: write_reg(CFG_SLAVE_ADDR, $urandom_range(1, 247));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_SILENCE, 16'd1);
        1: write_reg(CFG_SILENCE, 16'd2);
        2: write_reg(CFG_SILENCE, 16'd3);
        default: write_reg(CFG_SILENCE, $urandom_range(4, 12));
      endcase
      write_reg(CFG_ADU_MODE, $urandom_range(0, 1));
      if (!pressed) begin
        // one long read with the response side held off
        pressed = 1;
        hold_req = 1;
        fr.delete();
        if (m_adu) fr.push_back(m_addr);
        fr.push_back(FC_READ_HOLD);
        fr.push_back(8'h00);
        fr.push_back(8'h00);
        fr.push_back(8'h00);
        fr.push_back(8'h40);
        if (m_adu) append_crc(fr);
        send_frame(fr);
      end
      nframes = $urandom_range(4, 10);
      repeat (nframes) begin
        make_request(fr);
        send_frame(fr);
      end
    end

    // longest silence, bare pdu, no idling
    idle_on = 0;
    write_reg(CFG_SILENCE, 16'hFFFF);
    write_reg(CFG_ADU_MODE, 16'd0);
    fr = '{FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h04};
    send_frame(fr);
    write_reg(CFG_SILENCE, 16'd2);
    write_reg(CFG_ADU_MODE, 16'd1);

    // last stretch: back to back, no idling on either side
    rnd_ticks = ticks_sent;
    while (ticks_sent - rnd_ticks < 150) begin
      make_request(fr);
      send_frame(fr);
    end

    // receive overflow: a full buffer without a break latches the error for good
    repeat (256) send_tick(1'b1, $urandom_range(0, 255));
    repeat (20) send_tick($urandom_range(0, 1), $urandom_range(0, 255));

    while (expected_results.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
